// ===== src/tsc_pkg.sv =====
// Shared types and codes for the threshold scaler with cooldown.
package tsc_pkg;

    localparam int COUNT_W  = 10;
    localparam int METRIC_W = 32;
    localparam int WAIT_W   = 16;
    localparam int CFG_W    = 32;
    localparam int INDEX_W  = 3;
    localparam int OP_W     = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_PLAN   = 2'd0,
        OP_RECORD = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DEC_NONE = 2'd0,
        DEC_UP   = 2'd1,
        DEC_DOWN = 2'd2
    } decision_t;

    typedef enum logic [2:0] {
        RSN_IN_RANGE      = 3'd0,
        RSN_BELOW_MIN     = 3'd1,
        RSN_UP            = 3'd2,
        RSN_UP_COOLDOWN   = 3'd3,
        RSN_DOWN          = 3'd4,
        RSN_DOWN_COOLDOWN = 3'd5,
        RSN_NO_METRIC     = 3'd6
    } reason_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_MIN_COUNT      = 3'd0,
        REG_MAX_COUNT      = 3'd1,
        REG_STEP_SIZE      = 3'd2,
        REG_UP_THRESHOLD   = 3'd3,
        REG_DOWN_THRESHOLD = 3'd4,
        REG_UP_COOLDOWN    = 3'd5,
        REG_DOWN_COOLDOWN  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0]         mn;
        logic [COUNT_W-1:0]         mx;
        logic [COUNT_W-1:0]         st;
        logic signed [METRIC_W-1:0] up_th;
        logic signed [METRIC_W-1:0] down_th;
        logic [WAIT_W-1:0]          up_cd;
        logic [WAIT_W-1:0]          down_cd;
    } limits_t;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [COUNT_W-1:0]         cur;
        logic signed [METRIC_W-1:0] metric;
        logic                       metric_valid;
        logic [1:0]                 applied;
    } item_t;

    typedef struct packed {
        logic up_active;
        logic down_active;
    } cd_status_t;

    typedef struct packed {
        logic                       plan_ok;
        logic [1:0]                 decision;
        logic [COUNT_W-1:0]         desired;
        logic [2:0]                 reason;
        logic signed [METRIC_W-1:0] seen;
    } result_t;

endpackage

// ===== src/tsc_cfg_regs.sv =====
// Configuration registers and the effective replica limits derived from them.
module tsc_cfg_regs
    import tsc_pkg::*;
#(
    parameter int REPLICA_LIMIT = 1023
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output limits_t            limits
);

    localparam logic [16:0] MAX_EXT = 17'(REPLICA_LIMIT);

    logic [COUNT_W-1:0]  min_reg;
    logic [COUNT_W-1:0]  max_reg;
    logic [COUNT_W-1:0]  step_reg;
    logic [METRIC_W-1:0] up_th_reg;
    logic [METRIC_W-1:0] down_th_reg;
    logic [WAIT_W-1:0]   up_cd_reg;
    logic [WAIT_W-1:0]   down_cd_reg;

    logic [COUNT_W-1:0] mn_fix;
    logic [COUNT_W-1:0] mn_eff;
    logic [COUNT_W-1:0] mx_fix;
    logic [COUNT_W-1:0] mx_eff;
    logic [COUNT_W-1:0] st_fix;

    function automatic logic [COUNT_W-1:0] clamp_limit(input logic [COUNT_W-1:0] v);
        logic [16:0] v_ext;
        v_ext = 17'(v);
        return (v_ext > MAX_EXT) ? MAX_EXT[COUNT_W-1:0] : v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= COUNT_W'(1);
            max_reg     <= COUNT_W'(1);
            step_reg    <= COUNT_W'(1);
            up_th_reg   <= '0;
            down_th_reg <= '0;
            up_cd_reg   <= '0;
            down_cd_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_COUNT:      min_reg     <= cfg_data[COUNT_W-1:0];
                REG_MAX_COUNT:      max_reg     <= cfg_data[COUNT_W-1:0];
                REG_STEP_SIZE:      step_reg    <= cfg_data[COUNT_W-1:0];
                REG_UP_THRESHOLD:   up_th_reg   <= cfg_data[METRIC_W-1:0];
                REG_DOWN_THRESHOLD: down_th_reg <= cfg_data[METRIC_W-1:0];
                REG_UP_COOLDOWN:    up_cd_reg   <= cfg_data[WAIT_W-1:0];
                REG_DOWN_COOLDOWN:  down_cd_reg <= cfg_data[WAIT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        mn_fix = (min_reg == '0) ? COUNT_W'(1) : min_reg;
        mn_eff = clamp_limit(mn_fix);
        mx_fix = (max_reg < mn_eff) ? mn_eff : max_reg;
        mx_eff = clamp_limit(mx_fix);
        if (mx_eff < mn_eff)
        begin
            mx_eff = mn_eff;
        end
        st_fix = (step_reg == '0) ? COUNT_W'(1) : step_reg;

        limits.mn      = mn_eff;
        limits.mx      = mx_eff;
        limits.st      = clamp_limit(st_fix);
        limits.up_th   = up_th_reg;
        limits.down_th = down_th_reg;
        limits.up_cd   = up_cd_reg;
        limits.down_cd = down_cd_reg;
    end

endmodule

// ===== src/tsc_cooldown.sv =====
// Up and down cooldown counters, loaded by records and counted down by ticks.
module tsc_cooldown
    import tsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  item_t      item,
    input  limits_t    limits,
    output cd_status_t status
);

    logic [WAIT_W-1:0] up_wait_reg;
    logic [WAIT_W-1:0] up_wait_next;
    logic [WAIT_W-1:0] down_wait_reg;
    logic [WAIT_W-1:0] down_wait_next;

    always_comb
    begin
        up_wait_next   = up_wait_reg;
        down_wait_next = down_wait_reg;
        unique case (op_t'(item.op))
            OP_RECORD:
            begin
                if (item.applied == DEC_UP)
                begin
                    up_wait_next = limits.up_cd;
                end
                else if (item.applied == DEC_DOWN)
                begin
                    down_wait_next = limits.down_cd;
                end
            end
            OP_TICK:
            begin
                if (up_wait_reg != '0)
                begin
                    up_wait_next = up_wait_reg - WAIT_W'(1);
                end
                if (down_wait_reg != '0)
                begin
                    down_wait_next = down_wait_reg - WAIT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_wait_reg   <= '0;
            down_wait_reg <= '0;
        end
        else if (advance)
        begin
            up_wait_reg   <= up_wait_next;
            down_wait_reg <= down_wait_next;
        end
    end

    assign status.up_active   = (up_wait_reg != '0);
    assign status.down_active = (down_wait_reg != '0);

endmodule

// ===== src/tsc_plan.sv =====
// Plan evaluation: threshold checks, step and clamp of the replica count.
module tsc_plan
    import tsc_pkg::*;
(
    input  item_t      item,
    input  limits_t    limits,
    input  cd_status_t status,
    output result_t    result
);

    logic [COUNT_W:0]   up_sum;
    logic [COUNT_W-1:0] up_count;
    logic [COUNT_W-1:0] down_raw;
    logic [COUNT_W-1:0] down_count;

    always_comb
    begin
        up_sum   = {1'b0, item.cur} + {1'b0, limits.st};
        up_count = (up_sum > {1'b0, limits.mx}) ? limits.mx : up_sum[COUNT_W-1:0];
        down_raw = (item.cur > limits.st) ? (item.cur - limits.st) : limits.mn;
        down_count = (down_raw < limits.mn) ? limits.mn : down_raw;

        result.plan_ok  = 1'b0;
        result.decision = DEC_NONE;
        result.desired  = item.cur;
        result.reason   = RSN_IN_RANGE;
        result.seen     = '0;

        if (op_t'(item.op) == OP_PLAN)
        begin
            if (!item.metric_valid)
            begin
                result.reason = RSN_NO_METRIC;
            end
            else
            begin
                result.plan_ok = 1'b1;
                result.seen    = item.metric;
                priority if (item.cur < limits.mn)
                begin
                    result.desired  = limits.mn;
                    result.decision = DEC_UP;
                    result.reason   = RSN_BELOW_MIN;
                end
                else if (item.metric >= limits.up_th && item.cur < limits.mx)
                begin
                    if (!status.up_active)
                    begin
                        result.desired  = up_count;
                        result.decision = DEC_UP;
                        result.reason   = RSN_UP;
                    end
                    else
                    begin
                        result.reason = RSN_UP_COOLDOWN;
                    end
                end
                else if (item.metric <= limits.down_th && item.cur > limits.mn)
                begin
                    if (!status.down_active)
                    begin
                        result.desired  = down_count;
                        result.decision = DEC_DOWN;
                        result.reason   = RSN_DOWN;
                    end
                    else
                    begin
                        result.reason = RSN_DOWN_COOLDOWN;
                    end
                end
                else
                begin
                    result.reason = RSN_IN_RANGE;
                end
            end
        end
    end

endmodule

// ===== src/threshold_scaler_with_cooldown.sv =====
// Top level of the threshold scaler with cooldown: stream ports and pipeline registers.
// Results are registered: a request passes the input register, then the result register, before m_tvalid.
// Throughput: one request per cycle while m_tready does not stall; input and result registers form a two-stage pipe.
// Cooldown counters update as a request moves from the input to the result register.
// Reset: asynchronous, active low; pipe empty, registers at defaults, counters zero.
module threshold_scaler_with_cooldown
    import tsc_pkg::*;
#(
    parameter int REPLICA_LIMIT = 1023
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // current_count[9:0], metric_level[41:10], metric_valid[42],
    // applied_decision[44:43], zero fill [47:45]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // plan_ok[0], decision[2:1], desired_count[12:3], reason_code[15:13],
    // metric_seen[47:16]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    limits_t    limits;
    cd_status_t status;
    result_t    result;

    item_t   item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op           <= s_tuser;
            item_reg.cur          <= s_tdata[9:0];
            item_reg.metric       <= s_tdata[41:10];
            item_reg.metric_valid <= s_tdata[42];
            item_reg.applied      <= s_tdata[44:43];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    tsc_cfg_regs #(
        .REPLICA_LIMIT (REPLICA_LIMIT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    tsc_cooldown u_cooldown (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .limits  (limits),
        .status  (status)
    );

    tsc_plan u_plan (
        .item   (item_reg),
        .limits (limits),
        .status (status),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.seen, out_reg.reason, out_reg.desired,
                       out_reg.decision, out_reg.plan_ok};

endmodule

// ===== src/tsc_checker.sv =====
// Port-level checks for the threshold scaler with cooldown, bound to the top level.
module tsc_checker
    import tsc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [1:0] dec;
    logic [2:0] rsn;

    assign dec = m_tdata[2:1];
    assign rsn = m_tdata[15:13];

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while result side free");

    a_no_plan_no_decision: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> dec == DEC_NONE && m_tdata[47:16] == '0)
        else $error("decision or metric without evaluated plan");

    a_up_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && dec == DEC_UP |-> rsn == RSN_BELOW_MIN || rsn == RSN_UP)
        else $error("scale up with wrong reason");

    a_down_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && dec == DEC_DOWN |-> rsn == RSN_DOWN && m_tdata[0])
        else $error("scale down with wrong reason");

endmodule

bind threshold_scaler_with_cooldown tsc_checker u_tsc_checker (.*);
